/* src/tick_driven_calendar_clock_top_macros.svh */
// ---------------------------------------------------------------------------
// tick_driven_calendar_clock_top_macros.svh
// assertion shorthands shared by the calendar clock checks
// ---------------------------------------------------------------------------
`ifndef TICK_DRIVEN_CALENDAR_CLOCK_TOP_MACROS_SVH
`define TICK_DRIVEN_CALENDAR_CLOCK_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define TDCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar clock check failed");

// next-cycle implication, quiet during reset
`define TDCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar clock check failed");

`endif

/* src/tdcc_pkg.sv */
// ---------------------------------------------------------------------------
// tdcc_pkg
// types, constants and calendar helpers of the tick driven calendar clock
// ---------------------------------------------------------------------------
package tdcc_pkg;

    // field widths
    localparam int unsigned OP_W     = 3;
    localparam int unsigned TPS_W    = 16;
    localparam int unsigned YEAR_W   = 16;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned MS_W     = 10;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned TICKS_W  = 32;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_SYS_TICK    = 3'd0,
        OP_MS_TICK     = 3'd1,
        OP_SET_DATE    = 3'd2,
        OP_SET_TIME    = 3'd3,
        OP_SET_WEEKDAY = 3'd4
    } op_t;

    // status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // reset values
    localparam logic [TPS_W-1:0]    TPS_RESET   = 16'd1000;
    localparam logic [YEAR_W-1:0]   YEAR_RESET  = 16'd2000;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST = 4'd1;
    localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
    localparam logic [WDAY_W-1:0]   WDAY_SAT    = 3'd6;

    // limits
    localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;
    localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;
    localparam logic [MS_W-1:0]     MS_LAST     = 10'd999;
    localparam logic [WDAY_W-1:0]   WDAY_MON    = 3'd1;
    localparam logic [WDAY_W-1:0]   WDAY_SUN    = 3'd7;

    // divisibility by 25: multiply by the inverse mod 2^16, compare to 65535/25
    localparam logic [YEAR_W-1:0]   DIV25_INV   = 16'd23593;
    localparam logic [YEAR_W-1:0]   DIV25_MAX   = 16'd2621;

    // date and time of day
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MS_W-1:0]     millisecond;
        logic [WDAY_W-1:0]   weekday;
    } cal_t;

    // gregorian leap rule
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, DIV25_INV};
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // month length, 31 for month codes outside the year
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (m) inside
            4'd2:                   d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

/* src/tdcc_cmd_if.sv */
// ---------------------------------------------------------------------------
// tdcc_cmd_if
// command channel of the calendar clock: operation and set operands
// ---------------------------------------------------------------------------
interface tdcc_cmd_if import tdcc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [YEAR_W-1:0]   new_year;
    logic [MONTH_W-1:0]  new_month;
    logic [DAY_W-1:0]    new_day;
    logic [HOUR_W-1:0]   new_hour;
    logic [MINUTE_W-1:0] new_minute;
    logic [SECOND_W-1:0] new_second;
    logic [MS_W-1:0]     new_millisecond;
    logic [WDAY_W-1:0]   new_weekday;

    modport source (
        output valid, operation, new_year, new_month, new_day, new_hour,
               new_minute, new_second, new_millisecond, new_weekday,
        input  ready
    );

    modport sink (
        input  valid, operation, new_year, new_month, new_day, new_hour,
               new_minute, new_second, new_millisecond, new_weekday,
        output ready
    );

endinterface

/* src/tdcc_stamp_if.sv */
// ---------------------------------------------------------------------------
// tdcc_stamp_if
// result channel of the calendar clock: full date, time, status, tick total
// ---------------------------------------------------------------------------
interface tdcc_stamp_if import tdcc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [MS_W-1:0]     millisecond;
    logic [WDAY_W-1:0]   weekday;
    logic                status;
    logic [TICKS_W-1:0]  tick_total;

    modport source (
        output valid, year, month, day, hour, minute, second, millisecond,
               weekday, status, tick_total,
        input  ready
    );

    modport sink (
        input  valid, year, month, day, hour, minute, second, millisecond,
               weekday, status, tick_total,
        output ready
    );

endinterface

/* src/tick_driven_calendar_clock_top.sv */
// ---------------------------------------------------------------------------
// tick_driven_calendar_clock_top
// calendar clock driven by system and millisecond ticks, with checked sets
//
//   port    | kind       | moves
//   --------+------------+----------------------------------------------
//   cmd     | valid/rdy  | one operation item with its set operands
//   stamp   | valid/rdy  | date, time, weekday, status, tick total
//   wr_*    | write only | ticks per second register
//
// an item is taken into the input register, processed once the output register
// can take it, and held in the output register: 1 item per cycle sustained while
// stamp is not stalled; the update of the calendar registers sets the rate
// reset gives 2000-01-01 00:00:00.000, Saturday, 1000 ticks per second
// a stalled output freezes both stages; an empty input register can still fill
// ---------------------------------------------------------------------------
module tick_driven_calendar_clock_top import tdcc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [TPS_W-1:0] wr_data,
    tdcc_cmd_if.sink         cmd,
    tdcc_stamp_if.source     stamp
);

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [YEAR_W-1:0]   new_year;
        logic [MONTH_W-1:0]  new_month;
        logic [DAY_W-1:0]    new_day;
        logic [HOUR_W-1:0]   new_hour;
        logic [MINUTE_W-1:0] new_minute;
        logic [SECOND_W-1:0] new_second;
        logic [MS_W-1:0]     new_millisecond;
        logic [WDAY_W-1:0]   new_weekday;
    } cmd_t;

    logic [TPS_W-1:0]   tps_reg;
    logic               in_valid_reg;
    cmd_t               in_reg;
    cal_t               cal_reg;
    cal_t               cal_next;
    logic [TPS_W-1:0]   phase_reg;
    logic [TPS_W-1:0]   phase_next;
    logic [TICKS_W-1:0] ticks_reg;
    logic [TICKS_W-1:0] ticks_next;
    logic               status_next;
    logic               out_valid_reg;
    cal_t               out_cal_reg;
    logic               out_status_reg;
    logic [TICKS_W-1:0] out_ticks_reg;

    logic               advance;
    logic               work;
    logic [YEAR_W-1:0]  leap_year_sel;
    logic [MONTH_W-1:0] month_sel;
    logic               leap;
    logic [DAY_W-1:0]   dim;
    logic [TPS_W-1:0]   phase_inc;
    logic               phase_done;
    cal_t               rolled;

    // handshake: output register frees the pipe when empty or taken
    assign advance   = !out_valid_reg || stamp.ready;
    assign cmd.ready = !in_valid_reg || advance;
    assign work      = in_valid_reg && advance;

    // ticks per second register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (wr_en)
        begin
            tps_reg <= wr_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_reg <= '{operation:       cmd.operation,
                        new_year:        cmd.new_year,
                        new_month:       cmd.new_month,
                        new_day:         cmd.new_day,
                        new_hour:        cmd.new_hour,
                        new_minute:      cmd.new_minute,
                        new_second:      cmd.new_second,
                        new_millisecond: cmd.new_millisecond,
                        new_weekday:     cmd.new_weekday};
        end
    end

    // month length: the set operands for set date, the current date otherwise
    always_comb
    begin
        if (op_t'(in_reg.operation) == OP_SET_DATE)
        begin
            leap_year_sel = in_reg.new_year;
            month_sel     = in_reg.new_month;
        end
        else
        begin
            leap_year_sel = cal_reg.year;
            month_sel     = cal_reg.month;
        end
        leap = is_leap(leap_year_sel);
        dim  = month_days(month_sel, leap);
    end

    // one second later, carried through to the year
    always_comb
    begin
        rolled = cal_reg;
        if (cal_reg.second < SECOND_LAST)
        begin
            rolled.second = cal_reg.second + 1'b1;
        end
        else
        begin
            rolled.second = '0;
            if (cal_reg.minute < MINUTE_LAST)
            begin
                rolled.minute = cal_reg.minute + 1'b1;
            end
            else
            begin
                rolled.minute = '0;
                if (cal_reg.hour < HOUR_LAST)
                begin
                    rolled.hour = cal_reg.hour + 1'b1;
                end
                else
                begin
                    rolled.hour    = '0;
                    rolled.weekday = (cal_reg.weekday >= WDAY_SUN) ? WDAY_MON
                                                                   : cal_reg.weekday + 1'b1;
                    if (cal_reg.day < dim)
                    begin
                        rolled.day = cal_reg.day + 1'b1;
                    end
                    else
                    begin
                        rolled.day = DAY_FIRST;
                        if (cal_reg.month < MONTH_LAST)
                        begin
                            rolled.month = cal_reg.month + 1'b1;
                        end
                        else
                        begin
                            rolled.month = MONTH_FIRST;
                            rolled.year  = cal_reg.year + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // operation decode
    assign phase_inc  = phase_reg + 1'b1;
    assign phase_done = (phase_inc >= tps_reg);

    always_comb
    begin
        cal_next    = cal_reg;
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        status_next = STATUS_OK;
        unique case (op_t'(in_reg.operation))
            OP_SYS_TICK:
            begin
                ticks_next = ticks_reg + 1'b1;
                if (phase_done)
                begin
                    phase_next = '0;
                    cal_next   = rolled;
                end
                else
                begin
                    phase_next = phase_inc;
                end
            end
            OP_MS_TICK:
            begin
                if (cal_reg.millisecond >= MS_LAST)
                begin
                    cal_next             = rolled;
                    cal_next.millisecond = '0;
                end
                else
                begin
                    cal_next.millisecond = cal_reg.millisecond + 1'b1;
                end
            end
            OP_SET_DATE:
            begin
                if ((in_reg.new_month == '0) || (in_reg.new_month > MONTH_LAST) ||
                    (in_reg.new_day == '0) || (in_reg.new_day > dim))
                begin
                    status_next = STATUS_REJECT;
                end
                else
                begin
                    cal_next.year  = in_reg.new_year;
                    cal_next.month = in_reg.new_month;
                    cal_next.day   = in_reg.new_day;
                end
            end
            OP_SET_TIME:
            begin
                if ((in_reg.new_hour > HOUR_LAST) || (in_reg.new_minute > MINUTE_LAST) ||
                    (in_reg.new_second > SECOND_LAST) || (in_reg.new_millisecond > MS_LAST))
                begin
                    status_next = STATUS_REJECT;
                end
                else
                begin
                    cal_next.hour        = in_reg.new_hour;
                    cal_next.minute      = in_reg.new_minute;
                    cal_next.second      = in_reg.new_second;
                    cal_next.millisecond = in_reg.new_millisecond;
                end
            end
            OP_SET_WEEKDAY:
            begin
                if (in_reg.new_weekday == '0)
                begin
                    status_next = STATUS_REJECT;
                end
                else
                begin
                    cal_next.weekday = in_reg.new_weekday;
                end
            end
            default:
            begin
                status_next = STATUS_REJECT;
            end
        endcase
    end

    // calendar state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg   <= '{year:        YEAR_RESET,
                           month:       MONTH_FIRST,
                           day:         DAY_FIRST,
                           hour:        '0,
                           minute:      '0,
                           second:      '0,
                           millisecond: '0,
                           weekday:     WDAY_SAT};
            phase_reg <= '0;
            ticks_reg <= '0;
        end
        else if (work)
        begin
            cal_reg   <= cal_next;
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_cal_reg    <= cal_next;
            out_status_reg <= status_next;
            out_ticks_reg  <= ticks_next;
        end
    end

    assign stamp.valid       = out_valid_reg;
    assign stamp.year        = out_cal_reg.year;
    assign stamp.month       = out_cal_reg.month;
    assign stamp.day         = out_cal_reg.day;
    assign stamp.hour        = out_cal_reg.hour;
    assign stamp.minute      = out_cal_reg.minute;
    assign stamp.second      = out_cal_reg.second;
    assign stamp.millisecond = out_cal_reg.millisecond;
    assign stamp.weekday     = out_cal_reg.weekday;
    assign stamp.status      = out_status_reg;
    assign stamp.tick_total  = out_ticks_reg;

endmodule

/* src/tdcc_checker.sv */
// ---------------------------------------------------------------------------
// tdcc_checker
// port-level checks of the calendar clock, bound to the top level
// ---------------------------------------------------------------------------
`include "tick_driven_calendar_clock_top_macros.svh"

module tdcc_checker import tdcc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                stamp_valid,
    input logic                stamp_ready,
    input logic [YEAR_W-1:0]   year,
    input logic [MONTH_W-1:0]  month,
    input logic [DAY_W-1:0]    day,
    input logic [HOUR_W-1:0]   hour,
    input logic [MINUTE_W-1:0] minute,
    input logic [SECOND_W-1:0] second,
    input logic [MS_W-1:0]     millisecond,
    input logic [WDAY_W-1:0]   weekday,
    input logic                status,
    input logic [TICKS_W-1:0]  tick_total
);

    logic                          seen_reg;
    logic [TICKS_W-1:0]            last_ticks_reg;
    logic                          stamp_take;
    logic                          stamp_stall;
    logic                          in_range;
    logic                          ticks_ok;
    logic [$bits(cal_t)+TICKS_W:0] shown;

    assign stamp_take  = stamp_valid && stamp_ready;
    assign stamp_stall = stamp_valid && !stamp_ready;
    assign shown       = {year, month, day, hour, minute, second, millisecond, weekday,
                          status, tick_total};

    // month, day, time and weekday fields are in range; the day is checked only against its first value
    assign in_range = (month >= MONTH_FIRST) && (month <= MONTH_LAST) &&
                      (day >= DAY_FIRST) && (hour <= HOUR_LAST) &&
                      (minute <= MINUTE_LAST) && (second <= SECOND_LAST) &&
                      (millisecond <= MS_LAST) && (weekday >= WDAY_MON);

    // tick total moves by at most one from item to item
    assign ticks_ok = (tick_total == last_ticks_reg) ||
                      (tick_total == last_ticks_reg + 1'b1);

    // remember the tick total of the last item taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_ticks_reg <= '0;
        end
        else if (stamp_take)
        begin
            seen_reg       <= 1'b1;
            last_ticks_reg <= tick_total;
        end
    end

    `TDCC_ASSERT_NOW(a_stamp_in_range, clk, rst_n, stamp_valid, in_range)
    `TDCC_ASSERT_NOW(a_ticks_step, clk, rst_n, stamp_take && seen_reg, ticks_ok)
    `TDCC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !cmd_ready, stamp_stall)
    `TDCC_ASSERT_NEXT(a_stalled_item_holds, clk, rst_n, stamp_stall, stamp_valid && $stable(shown))

endmodule

bind tick_driven_calendar_clock_top tdcc_checker u_tdcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .stamp_valid (stamp.valid),
    .stamp_ready (stamp.ready),
    .year        (stamp.year),
    .month       (stamp.month),
    .day         (stamp.day),
    .hour        (stamp.hour),
    .minute      (stamp.minute),
    .second      (stamp.second),
    .millisecond (stamp.millisecond),
    .weekday     (stamp.weekday),
    .status      (stamp.status),
    .tick_total  (stamp.tick_total)
);
